// ===== rtl/pptbl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pptbl_pkg
// Types and constants shared by the per-player token bucket limiter.
// ----------------------------------------------------------------------------
package pptbl_pkg;

   localparam int OPCODE_W   = 1;
   localparam int IN_SLOT_W  = 6;
   localparam int PAYLOAD_W  = 16;
   localparam int CHAN_W     = 8;
   localparam int STAMP_W    = 32;
   localparam int LEVEL_W    = 26;
   localparam int RATE_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int COST_W     = PAYLOAD_W + 1;
   localparam int PROD_W     = STAMP_W + RATE_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LEVEL_W;

   // every value of the input slot field has an entry in the slot map
   localparam int INPUT_SLOTS = 1 << IN_SLOT_W;

   localparam logic [COST_W-1:0] TOKEN_UNIT = COST_W'(1024);

   localparam logic [OPCODE_W-1:0] OP_MESSAGE = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CHANNEL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RATE_LIMIT  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_BURST_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REFILL_RATE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PAYLOAD    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_CHANNEL    = 2'd3;

   localparam logic [LEVEL_W-1:0]   RST_BURST_CAPACITY = LEVEL_W'(32768);
   localparam logic [RATE_W-1:0]    RST_REFILL_RATE    = RATE_W'(10);
   localparam logic [PAYLOAD_W-1:0] RST_MAX_PAYLOAD    = PAYLOAD_W'(4096);
   localparam logic [CHAN_W-1:0]    RST_MAX_CHANNEL    = CHAN_W'(64);

   typedef struct packed {
      logic [OPCODE_W-1:0]  opcode;
      logic [PAYLOAD_W-1:0] payload_bytes;
      logic [CHAN_W-1:0]    channel_length;
      logic [STAMP_W-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic                 valid;
      logic [LEVEL_W-1:0]   level;
      logic [STAMP_W-1:0]   stamp;
   } entry_type;

   typedef struct packed {
      logic                 en;
      entry_type            data;
   } wr_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   burst_capacity;
      logic [RATE_W-1:0]    refill_rate;
      logic [PAYLOAD_W-1:0] max_payload_bytes;
      logic [CHAN_W-1:0]    max_channel_bytes;
   } cfg_type;

   typedef struct packed {
      logic                 has_result;
      logic                 accepted;
      logic [STATUS_W-1:0]  status;
      logic [LEVEL_W-1:0]   tokens_left;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/pptbl_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pptbl request and response channels
// Valid/ready channels carrying limiter requests and verdicts.
// ----------------------------------------------------------------------------
interface pptbl_req_if;
   logic                            valid;
   logic                            ready;
   logic [pptbl_pkg::OPCODE_W-1:0]  opcode;
   logic [pptbl_pkg::IN_SLOT_W-1:0] player_slot;
   logic [pptbl_pkg::PAYLOAD_W-1:0] payload_bytes;
   logic [pptbl_pkg::CHAN_W-1:0]    channel_length;
   logic [pptbl_pkg::STAMP_W-1:0]   now_ms;

   modport source (
      output valid, opcode, player_slot, payload_bytes, channel_length, now_ms,
      input  ready
   );
   modport sink (
      input  valid, opcode, player_slot, payload_bytes, channel_length, now_ms,
      output ready
   );
endinterface

interface pptbl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           accepted;
   logic [pptbl_pkg::STATUS_W-1:0] status;
   logic [pptbl_pkg::LEVEL_W-1:0]  tokens_left;

   modport source (
      output valid, accepted, status, tokens_left,
      input  ready
   );
   modport sink (
      input  valid, accepted, status, tokens_left,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/pptbl_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pptbl_table
// Bucket table: one entry per slot, registered read with write bypass and
// a clearing pass after reset.
// ----------------------------------------------------------------------------
module pptbl_table #(
   parameter int PLAYER_SLOTS = 64,
   parameter int SLOT_W       = 6
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        rd_en,
   input  wire  [SLOT_W-1:0]          rd_addr,
   input  pptbl_pkg::wr_type          wr,
   input  wire  [SLOT_W-1:0]          wr_addr,
   output pptbl_pkg::entry_type       rd_data,
   output logic                       busy
);

   pptbl_pkg::entry_type mem [PLAYER_SLOTS];
   pptbl_pkg::entry_type mem_q_ff;
   pptbl_pkg::entry_type byp_data_ff;
   logic                 byp_ff, byp_in;
   logic                 busy_ff, busy_in;
   logic [SLOT_W-1:0]    clr_ff, clr_in;
   logic                 mem_we;
   logic [SLOT_W-1:0]    mem_waddr;
   pptbl_pkg::entry_type mem_wdata;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PLAYER_SLOTS - 1);

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + SLOT_W'(1);
         if (clr_ff == LAST_SLOT) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = wr.en;
         mem_waddr = wr_addr;
         mem_wdata = wr.data;
      end
   end

   // a read at the address being written takes the new entry
   assign byp_in = rd_en ? (wr.en && (wr_addr == rd_addr)) : byp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
         byp_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
         byp_ff  <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         mem_q_ff    <= mem[rd_addr];
         byp_data_ff <= wr.data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : mem_q_ff;
   assign busy    = busy_ff;

endmodule
`default_nettype wire

// ===== rtl/pptbl_calc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pptbl_calc
// Checks a request, refills and charges the slot's bucket, and forms the
// verdict and the table update; a removal marks the slot unused instead.
// ----------------------------------------------------------------------------
module pptbl_calc (
   input  pptbl_pkg::req_type    item,
   input  pptbl_pkg::entry_type  entry,
   input  pptbl_pkg::cfg_type    cfg,
   output pptbl_pkg::rsp_type    rsp,
   output pptbl_pkg::wr_type     wr
);

   logic                                bad_chan;
   logic                                too_big;
   logic [pptbl_pkg::LEVEL_W-1:0]       cur_level;
   logic [pptbl_pkg::STAMP_W-1:0]       cur_stamp;
   logic [pptbl_pkg::STAMP_W-1:0]       elapsed;
   logic [pptbl_pkg::PROD_W-1:0]        product;
   logic [pptbl_pkg::SUM_W-1:0]         sum;
   logic [pptbl_pkg::LEVEL_W-1:0]       refill_level;
   logic [pptbl_pkg::COST_W-1:0]        cost;
   logic                                limited;
   logic [pptbl_pkg::LEVEL_W-1:0]       after_level;
   logic [pptbl_pkg::LEVEL_W-1:0]       held_level;

   assign bad_chan = (item.channel_length == '0) ||
                     (item.channel_length > cfg.max_channel_bytes);
   assign too_big  = item.payload_bytes > cfg.max_payload_bytes;

   // first use starts full with no refill
   assign cur_level = entry.valid ? entry.level : cfg.burst_capacity;
   assign cur_stamp = entry.valid ? entry.stamp : item.now_ms;

   assign elapsed = item.now_ms - cur_stamp;
   assign product = pptbl_pkg::PROD_W'(elapsed) * pptbl_pkg::PROD_W'(cfg.refill_rate);
   assign sum     = pptbl_pkg::SUM_W'(cur_level) + pptbl_pkg::SUM_W'(product);

   always_comb begin
      priority if (elapsed == '0) begin
         refill_level = cur_level;
      end else if (sum > pptbl_pkg::SUM_W'(cfg.burst_capacity)) begin
         refill_level = cfg.burst_capacity;
      end else begin
         refill_level = sum[pptbl_pkg::LEVEL_W-1:0];
      end
   end

   assign cost        = pptbl_pkg::TOKEN_UNIT + pptbl_pkg::COST_W'(item.payload_bytes);
   assign limited     = refill_level < pptbl_pkg::LEVEL_W'(cost);
   assign after_level = refill_level - pptbl_pkg::LEVEL_W'(cost);
   assign held_level  = entry.valid ? entry.level : '0;

   always_comb begin
      rsp             = '0;
      wr.en           = 1'b0;
      wr.data.valid   = 1'b1;
      wr.data.level   = refill_level;
      wr.data.stamp   = item.now_ms;
      priority if (item.opcode == pptbl_pkg::OP_REMOVE) begin
         wr.en         = 1'b1;
         wr.data.valid = 1'b0;
         wr.data.level = entry.level;
         wr.data.stamp = entry.stamp;
      end else if (bad_chan) begin
         rsp.has_result  = 1'b1;
         rsp.status      = pptbl_pkg::STATUS_BAD_CHANNEL;
         rsp.tokens_left = held_level;
      end else if (too_big) begin
         rsp.has_result  = 1'b1;
         rsp.status      = pptbl_pkg::STATUS_TOO_LARGE;
         rsp.tokens_left = held_level;
      end else if (limited) begin
         // keep the refill, no charge
         wr.en           = 1'b1;
         rsp.has_result  = 1'b1;
         rsp.status      = pptbl_pkg::STATUS_RATE_LIMIT;
         rsp.tokens_left = refill_level;
      end else begin
         wr.en           = 1'b1;
         wr.data.level   = after_level;
         rsp.has_result  = 1'b1;
         rsp.accepted    = 1'b1;
         rsp.status      = pptbl_pkg::STATUS_OK;
         rsp.tokens_left = after_level;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/per_player_token_bucket_limiter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// per_player_token_bucket_limiter
// Token-bucket policer with one bucket per player slot.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one transaction per message or player removal; rsp_if
//   returns one verdict (accepted, status, tokens_left) per message and none
//   per removal. csr_wr_en/csr_index/csr_wr_data write the four limits; write
//   them only while no transaction is in flight.
//   A verdict is held in the result register; the table read registers
//   with the request in the update stage, ahead of the result register.
//   Throughput: one transaction per cycle unless rsp_if stalls, even
//   back-to-back for the same slot; the read bypasses the update being written.
//   The critical path is the elapsed-time by refill-rate multiply followed
//   by the saturating add and the charge compare.
//   Reset: limits return to their defaults, then a clearing pass marks
//   every slot unused in turn; req_if.ready stays low meanwhile.
//   Stall: while rsp_if.ready is low and a verdict waits, the pipeline holds
//   and req_if.ready drops once the update stage is occupied.
// ----------------------------------------------------------------------------
module per_player_token_bucket_limiter #(
   parameter int PLAYER_SLOTS = 64
) (
   input  wire                                clock,
   input  wire                                reset,
   pptbl_req_if.sink                          req_if,
   pptbl_rsp_if.source                        rsp_if,
   input  wire                                csr_wr_en,
   input  wire  [pptbl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [pptbl_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int SLOT_W = $clog2(PLAYER_SLOTS);

   pptbl_pkg::cfg_type   cfg_ff, cfg_in;
   logic                 s1_valid_ff, s1_valid_in;
   pptbl_pkg::req_type   s1_item_ff;
   logic [SLOT_W-1:0]    s1_slot_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   pptbl_pkg::rsp_type   rsp_ff;
   logic                 advance;
   logic                 req_take;
   logic                 busy;
   logic [SLOT_W-1:0]    req_slot;
   pptbl_pkg::entry_type entry;
   pptbl_pkg::rsp_type   calc_rsp;
   pptbl_pkg::wr_type    calc_wr;
   pptbl_pkg::wr_type    tbl_wr;
   pptbl_pkg::req_type   req_item;
   logic [SLOT_W-1:0]    slot_map [pptbl_pkg::INPUT_SLOTS];

   // slot field reduced modulo the table depth
   for (genvar i = 0; i < pptbl_pkg::INPUT_SLOTS; i++) begin : g_slot_map
      assign slot_map[i] = SLOT_W'(i % PLAYER_SLOTS);
   end

   assign req_slot = slot_map[req_if.player_slot];

   assign req_item.opcode         = req_if.opcode;
   assign req_item.payload_bytes  = req_if.payload_bytes;
   assign req_item.channel_length = req_if.channel_length;
   assign req_item.now_ms         = req_if.now_ms;

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !busy && (!s1_valid_ff || advance);
   assign req_take     = req_if.valid && req_if.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pptbl_pkg::REG_BURST_CAPACITY: cfg_in.burst_capacity = csr_wr_data;
            pptbl_pkg::REG_REFILL_RATE:
               cfg_in.refill_rate = csr_wr_data[pptbl_pkg::RATE_W-1:0];
            pptbl_pkg::REG_MAX_PAYLOAD:
               cfg_in.max_payload_bytes = csr_wr_data[pptbl_pkg::PAYLOAD_W-1:0];
            pptbl_pkg::REG_MAX_CHANNEL:
               cfg_in.max_channel_bytes = csr_wr_data[pptbl_pkg::CHAN_W-1:0];
         endcase
      end
   end

   pptbl_table #(
      .PLAYER_SLOTS (PLAYER_SLOTS),
      .SLOT_W       (SLOT_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (req_slot),
      .wr      (tbl_wr),
      .wr_addr (s1_slot_ff),
      .rd_data (entry),
      .busy    (busy)
   );

   pptbl_calc u_calc (
      .item  (s1_item_ff),
      .entry (entry),
      .cfg   (cfg_ff),
      .rsp   (calc_rsp),
      .wr    (calc_wr)
   );

   // commit the update only when the transaction leaves the update stage
   always_comb begin
      tbl_wr    = calc_wr;
      tbl_wr.en = calc_wr.en && s1_valid_ff && advance;
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         s1_valid_in  = req_take;
         rsp_valid_in = s1_valid_ff && calc_rsp.has_result;
      end else if (req_take) begin
         // fill the empty update stage while the verdict waits
         s1_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.burst_capacity    <= pptbl_pkg::RST_BURST_CAPACITY;
         cfg_ff.refill_rate       <= pptbl_pkg::RST_REFILL_RATE;
         cfg_ff.max_payload_bytes <= pptbl_pkg::RST_MAX_PAYLOAD;
         cfg_ff.max_channel_bytes <= pptbl_pkg::RST_MAX_CHANNEL;
         s1_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
         s1_slot_ff <= req_slot;
      end
      if (advance) begin
         rsp_ff <= calc_rsp;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.accepted    = rsp_ff.accepted;
   assign rsp_if.status      = rsp_ff.status;
   assign rsp_if.tokens_left = rsp_ff.tokens_left;

`ifndef SYNTHESIS
   a_no_take_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_if.ready)
      else $error("request taken during table clearing pass");

   a_stage_empty_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy |-> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline occupied during table clearing pass");

   a_accept_means_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.accepted == (rsp_ff.status == pptbl_pkg::STATUS_OK)))
      else $error("accepted flag disagrees with status");

   a_result_from_message: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && s1_item_ff.opcode == pptbl_pkg::OP_REMOVE)
      |=> !rsp_valid_ff)
      else $error("verdict produced for a removal");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-player token bucket limiter. A queue of
// pending requests feeds a clocked driver; a clocked monitor polices every
// request taken, keeps its own copy of the bucket table and limits, and
// compares each verdict against the oldest outstanding one. Directed cases
// come first, then random traffic under several limit settings, with random
// gaps on the request side and random stalls on the verdict side.
// ----------------------------------------------------------------------------
module tb_top;
   import pptbl_pkg::*;

   localparam int PLAYER_SLOTS = 64;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PRINT_LIMIT  = 50;

   typedef struct packed {
      logic [OPCODE_W-1:0]  opcode;
      logic [IN_SLOT_W-1:0] player_slot;
      logic [PAYLOAD_W-1:0] payload_bytes;
      logic [CHAN_W-1:0]    channel_length;
      logic [STAMP_W-1:0]   now_ms;
   } item_type;

   typedef struct packed {
      logic                accepted;
      logic [STATUS_W-1:0] status;
      logic [LEVEL_W-1:0]  tokens_left;
   } verdict_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   pptbl_req_if req_bus ();
   pptbl_rsp_if rsp_bus ();

   per_player_token_bucket_limiter #(
      .PLAYER_SLOTS (PLAYER_SLOTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // limits as the block should currently hold them
   logic [LEVEL_W-1:0]   lim_burst   = RST_BURST_CAPACITY;
   logic [RATE_W-1:0]    lim_rate    = RST_REFILL_RATE;
   logic [PAYLOAD_W-1:0] lim_payload = RST_MAX_PAYLOAD;
   logic [CHAN_W-1:0]    lim_channel = RST_MAX_CHANNEL;

   // bucket table mirror
   logic                 bucket_live  [PLAYER_SLOTS];
   logic [LEVEL_W-1:0]   bucket_level [PLAYER_SLOTS];
   logic [STAMP_W-1:0]   bucket_stamp [PLAYER_SLOTS];

   item_type    request_q [$];
   verdict_type verdict_q [$];

   logic [STAMP_W-1:0] wall_ms;
   bit steady = 1'b0;
   int send_gap;
   int stall_left;
   int fault_count = 0;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      if (fault_count < PRINT_LIMIT)
         $display("ERROR @%0t: %s", $time, msg);
      fault_count++;
   endtask

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady || pick < 65)
         return 0;
      else if (pick < 94)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 30);
   endfunction

   // Apply one taken request to the bucket mirror and queue its verdict.
   task automatic police_item(input item_type it);
      int                 s;
      logic [STAMP_W-1:0] elapsed;
      logic [63:0]        refilled;
      logic [COST_W-1:0]  charge;
      logic [LEVEL_W-1:0] held;
      s = int'(it.player_slot) % PLAYER_SLOTS;
      held = bucket_live[s] ? bucket_level[s] : '0;
      if (it.opcode == OP_REMOVE) begin
         bucket_live[s] = 1'b0;
      end else if (it.channel_length == '0 || it.channel_length > lim_channel) begin
         verdict_q.push_back('{accepted: 1'b0, status: STATUS_BAD_CHANNEL, tokens_left: held});
      end else if (it.payload_bytes > lim_payload) begin
         verdict_q.push_back('{accepted: 1'b0, status: STATUS_TOO_LARGE, tokens_left: held});
      end else begin
         if (!bucket_live[s]) begin
            bucket_live[s]  = 1'b1;
            bucket_level[s] = lim_burst;
            bucket_stamp[s] = it.now_ms;
         end
         elapsed = it.now_ms - bucket_stamp[s];
         if (elapsed != '0) begin
            refilled = 64'(bucket_level[s]) + 64'(elapsed) * 64'(lim_rate);
            if (refilled > 64'(lim_burst))
               refilled = 64'(lim_burst);
            bucket_level[s] = refilled[LEVEL_W-1:0];
            bucket_stamp[s] = it.now_ms;
         end
         charge = TOKEN_UNIT + COST_W'(it.payload_bytes);
         if (COST_W'(bucket_level[s]) < charge && bucket_level[s] < LEVEL_W'(charge)) begin
            verdict_q.push_back('{accepted: 1'b0, status: STATUS_RATE_LIMIT,
                                  tokens_left: bucket_level[s]});
         end else begin
            bucket_level[s] = bucket_level[s] - LEVEL_W'(charge);
            verdict_q.push_back('{accepted: 1'b1, status: STATUS_OK,
                                  tokens_left: bucket_level[s]});
         end
      end
   endtask

   always @(posedge clock) begin : drive
      item_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         // a transaction was just taken: maybe idle before the next
         if (req_bus.valid)
            send_gap = gap_length();
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (request_q.size() != 0) begin
            next_item = request_q.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.opcode         <= next_item.opcode;
            req_bus.player_slot    <= next_item.player_slot;
            req_bus.payload_bytes  <= next_item.payload_bytes;
            req_bus.channel_length <= next_item.channel_length;
            req_bus.now_ms         <= next_item.now_ms;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : observe
      verdict_type want;
      item_type    taken;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         // check verdicts before policing this edge's request
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdict_q.size() == 0) begin
               flag_error("verdict with nothing outstanding");
            end else begin
               want = verdict_q.pop_front();
               if (rsp_bus.accepted !== want.accepted)
                  flag_error($sformatf("accepted %0b, want %0b",
                                       rsp_bus.accepted, want.accepted));
               if (rsp_bus.status !== want.status)
                  flag_error($sformatf("status %0d, want %0d", rsp_bus.status, want.status));
               if (rsp_bus.tokens_left !== want.tokens_left)
                  flag_error($sformatf("tokens_left %0d, want %0d",
                                       rsp_bus.tokens_left, want.tokens_left));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            taken.opcode         = req_bus.opcode;
            taken.player_slot    = req_bus.player_slot;
            taken.payload_bytes  = req_bus.payload_bytes;
            taken.channel_length = req_bus.channel_length;
            taken.now_ms         = req_bus.now_ms;
            police_item(taken);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = gap_length();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic item_type make_item(input logic [OPCODE_W-1:0] op, input int slot,
                                          input int pay, input int chan,
                                          input logic [STAMP_W-1:0] stamp);
      item_type it;
      it.opcode         = op;
      it.player_slot    = IN_SLOT_W'(slot);
      it.payload_bytes  = PAYLOAD_W'(pay);
      it.channel_length = CHAN_W'(chan);
      it.now_ms         = stamp;
      return it;
   endfunction

   function automatic item_type random_item();
      item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      it.opcode = (pick < 5) ? OP_REMOVE : OP_MESSAGE;
      // keep most traffic on a few hot slots so buckets actually drain
      if ($urandom_range(0, 9) < 7)
         it.player_slot = IN_SLOT_W'($urandom_range(0, 7));
      else
         it.player_slot = IN_SLOT_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 85)
         it.channel_length = CHAN_W'($urandom_range(1, int'(lim_channel)));
      else if (pick < 90)
         it.channel_length = '0;
      else if (pick < 95 && lim_channel != 8'hFF)
         it.channel_length = CHAN_W'($urandom_range(int'(lim_channel) + 1, 255));
      else
         it.channel_length = CHAN_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 50)
         it.payload_bytes = PAYLOAD_W'($urandom_range(0,
                               (int'(lim_payload) < 2047) ? int'(lim_payload) : 2047));
      else if (pick < 80)
         it.payload_bytes = PAYLOAD_W'($urandom_range(0, int'(lim_payload)));
      else if (pick < 90 && lim_payload != 16'hFFFF)
         it.payload_bytes = PAYLOAD_W'($urandom_range(int'(lim_payload) + 1, 65535));
      else
         it.payload_bytes = PAYLOAD_W'($urandom);
      // time mostly stands still or creeps; now and then it jumps anywhere
      pick = $urandom_range(0, 99);
      if (pick >= 97)
         wall_ms = $urandom;
      else if (pick >= 85)
         wall_ms = wall_ms + STAMP_W'($urandom_range(21, 4000));
      else if (pick >= 55)
         wall_ms = wall_ms + STAMP_W'($urandom_range(1, 20));
      it.now_ms = wall_ms;
      return it;
   endfunction

   task automatic wait_idle();
      while (request_q.size() != 0 || req_bus.valid || verdict_q.size() != 0)
         @(negedge clock);
      // a trailing removal leaves nothing to wait for; cover its latency
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value, input int width);
      logic [31:0] mask;
      mask = (32'd1 << width) - 32'd1;
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      // junk above the register width must be dropped
      csr_wr_data <= CSR_DATA_W'(($urandom & ~mask) | (32'(value) & mask));
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_limits(input int burst, input int rate, input int pay, input int chan);
      write_csr(REG_BURST_CAPACITY, burst, LEVEL_W);
      write_csr(REG_REFILL_RATE, rate, RATE_W);
      write_csr(REG_MAX_PAYLOAD, pay, PAYLOAD_W);
      write_csr(REG_MAX_CHANNEL, chan, CHAN_W);
      lim_burst   = LEVEL_W'(burst);
      lim_rate    = RATE_W'(rate);
      lim_payload = PAYLOAD_W'(pay);
      lim_channel = CHAN_W'(chan);
   endtask

   task automatic run_random(input int count);
      int left;
      int chunk;
      left = count;
      while (left > 0) begin
         chunk = $urandom_range(20, 60);
         if (chunk > left)
            chunk = left;
         steady = ($urandom_range(0, 3) == 0);
         repeat (chunk) request_q.push_back(random_item());
         left -= chunk;
         while (request_q.size() != 0)
            @(negedge clock);
         // now and then hold the sender until every verdict is back
         if ($urandom_range(0, 7) == 0)
            wait_idle();
      end
   endtask

   initial begin : stimulus
      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_index              = '0;
      csr_wr_data            = '0;
      req_bus.valid          = 1'b0;
      req_bus.opcode         = OP_MESSAGE;
      req_bus.player_slot    = '0;
      req_bus.payload_bytes  = '0;
      req_bus.channel_length = '0;
      req_bus.now_ms         = '0;
      rsp_bus.ready          = 1'b0;
      for (int s = 0; s < PLAYER_SLOTS; s++) begin
         bucket_live[s]  = 1'b0;
         bucket_level[s] = '0;
         bucket_stamp[s] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed cases under the reset limits
      request_q.push_back(make_item(OP_MESSAGE, 0, 0, 0, 100));
      request_q.push_back(make_item(OP_MESSAGE, 0, 0, 65, 100));
      request_q.push_back(make_item(OP_MESSAGE, 0, 4097, 1, 100));
      request_q.push_back(make_item(OP_MESSAGE, 0, 65535, 0, 100));
      request_q.push_back(make_item(OP_MESSAGE, 0, 4096, 64, 100));
      request_q.push_back(make_item(OP_MESSAGE, 0, 0, 1, 100));
      request_q.push_back(make_item(OP_MESSAGE, 0, 0, 255, 100));
      request_q.push_back(make_item(OP_MESSAGE, 0, 65535, 10, 100));
      request_q.push_back(make_item(OP_MESSAGE, 63, 0, 1, 32'hFFFF_FFFF));
      request_q.push_back(make_item(OP_MESSAGE, 63, 1023, 1, 5));
      request_q.push_back(make_item(OP_MESSAGE, 0, 0, 1, 50));
      request_q.push_back(make_item(OP_REMOVE, 0, 0, 0, 60));
      request_q.push_back(make_item(OP_REMOVE, 0, 0, 0, 60));
      request_q.push_back(make_item(OP_MESSAGE, 0, 0, 3, 60));
      request_q.push_back(make_item(OP_MESSAGE, 0, 100, 3, 60));
      // drain one bucket until refused, then let a millisecond pass
      repeat (7) request_q.push_back(make_item(OP_MESSAGE, 5, 4096, 64, 1000));
      request_q.push_back(make_item(OP_MESSAGE, 5, 0, 1, 1001));
      request_q.push_back(make_item(OP_MESSAGE, 5, 4096, 64, 1001));
      wait_idle();

      wall_ms = $urandom;
      set_limits($urandom_range(2048, 200000), $urandom_range(1, 200),
                 $urandom_range(100, 8000), $urandom_range(8, 200));
      run_random(350);
      wait_idle();

      set_limits(32'h3FF_FFFF, 32'hFFFF, 32'hFFFF, 32'hFF);
      run_random(300);
      wait_idle();

      set_limits(0, 0, 0, 1);
      // levels above the new ceiling survive while no time has passed
      for (int s = 0; s < 8; s++)
         if (bucket_live[s])
            request_q.push_back(make_item(OP_MESSAGE, s, 0, 1, bucket_stamp[s]));
      run_random(200);
      wait_idle();

      set_limits(4096, $urandom_range(1, 30), 3000, 32);
      run_random(400);
      wait_idle();

      set_limits($urandom_range(0, 32'h3FF_FFFF), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(1, 255));
      run_random(450);
      wait_idle();

      repeat (8) @(negedge clock);
      if (verdict_q.size() != 0)
         flag_error($sformatf("%0d verdicts never arrived", verdict_q.size()));
      if (fault_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pptbl_pkg.sv
rtl/pptbl_ifs.sv
rtl/pptbl_table.sv
rtl/pptbl_calc.sv
rtl/per_player_token_bucket_limiter.sv
tb/tb_top.sv
